@@ rtl/slw_pkg.sv @@
// Shared types, character codes and helpers for the S-record window loader.
package slw_pkg;

	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_NL    = 8'h0a;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_EOS  = 1'b1;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic REG_WINDOW_LOW  = 1'b0;
	localparam logic REG_WINDOW_HIGH = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		EV_STORE     = 2'd0,
		EV_STORE_END = 2'd1,
		EV_END       = 2'd2,
		EV_EOS       = 2'd3
	} ev_op_t;

	typedef struct packed {
		ev_op_t      op;
		logic [7:0]  ch;
	} ev_t;

	typedef enum logic [1:0] {
		RK_IGNORE = 2'd0,
		RK_S1     = 2'd1,
		RK_S2     = 2'd2,
		RK_S_SEEN = 2'd3
	} rec_kind_t;

	typedef struct packed {
		logic         kind;
		logic [23:0]  offset;
		logic [7:0]   byte_value;
		logic [15:0]  line_count;
		logic         terminator_seen;
	} res_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

@@ rtl/slw_front.sv @@
// Front end: escape and line-length handling, turns characters into line events.
module slw_front #(
	parameter int LINE_LIMIT = 520
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          cmd,
	input  logic [7:0]    ch,
	output logic          push,
	output slw_pkg::ev_t  ev
);
	import slw_pkg::*;

	localparam int SW = $clog2(LINE_LIMIT);
	localparam logic [SW-1:0] STEP_MAX = SW'(LINE_LIMIT - 1);

	logic [SW-1:0] steps_q, steps_n;
	logic          esc_q, esc_n;
	logic [SW-1:0] steps_inc;

	assign steps_inc = steps_q + SW'(1);

	always_comb begin
		steps_n = steps_q;
		esc_n   = esc_q;
		push    = 1'b0;
		ev.op   = EV_STORE;
		ev.ch   = ch;
		if (accept) begin
			if (cmd == CMD_EOS) begin
				push    = 1'b1;
				ev.op   = EV_EOS;
				steps_n = '0;
				esc_n   = 1'b0;
			end else if (esc_q) begin
				// The swallowed character can still close a line that is at its limit.
				esc_n = 1'b0;
				if (steps_q >= STEP_MAX) begin
					push    = 1'b1;
					ev.op   = EV_END;
					steps_n = '0;
				end
			end else if (ch == CH_NL) begin
				push    = 1'b1;
				ev.op   = EV_END;
				steps_n = '0;
			end else if (ch == CH_BSL) begin
				esc_n   = 1'b1;
				steps_n = steps_inc;
			end else if (steps_inc >= STEP_MAX) begin
				push    = 1'b1;
				ev.op   = EV_STORE_END;
				steps_n = '0;
			end else begin
				push    = 1'b1;
				ev.op   = EV_STORE;
				steps_n = steps_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			esc_q   <= 1'b0;
		end else begin
			steps_q <= steps_n;
			esc_q   <= esc_n;
		end
	end

endmodule

@@ rtl/slw_queue.sv @@
// Two-entry event queue between the front end and the record decoder.
module slw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  slw_pkg::ev_t  push_ev,
	output logic          full,
	output logic          ev_valid,
	output slw_pkg::ev_t  ev,
	input  logic          pop
);
	import slw_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	ev_t             mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     count_q;
	logic            do_pop;

	assign full     = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign ev_valid = (count_q != '0);
	assign ev       = mem_q[rd_q];
	assign do_pop   = pop && ev_valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push && !full) - (PW+1)'(do_pop);
		end
	end

endmodule

@@ rtl/slw_back.sv @@
// Record decoder: hex fields, window test, line counting and the result register.
module slw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ev_valid,
	input  slw_pkg::ev_t  ev,
	output logic          pop,
	input  logic [23:0]   window_low,
	input  logic [23:0]   window_high,
	output logic          res_valid,
	output slw_pkg::res_t res,
	input  logic          res_ready
);
	import slw_pkg::*;

	logic [9:0]   pos_q, pos_n;
	rec_kind_t    kind_q, kind_n;
	logic [7:0]   count_q, count_n;
	logic [23:0]  addr_q, addr_n;
	logic [24:0]  cur_q, cur_n;
	logic [3:0]   nib_q, nib_n;
	logic [7:0]   idx_q, idx_n;
	logic [15:0]  lines_q, lines_n;
	logic         finished_q, finished_n;

	logic         res_valid_q;
	res_t         res_q;

	logic         do_store, do_end, work;
	logic         hit;
	res_t         hit_res;
	logic [3:0]   nib;
	logic [7:0]   pair;
	logic [8:0]   pair_no;
	logic [8:0]   addr_bytes;
	logic         s9;
	logic [15:0]  ls_new;

	assign pop       = ev_valid && (!res_valid_q || res_ready);
	assign work      = pop && !finished_q;
	assign do_store  = (ev.op == EV_STORE) || (ev.op == EV_STORE_END);
	assign do_end    = (ev.op == EV_STORE_END) || (ev.op == EV_END);
	assign nib       = hex_value(ev.ch);
	assign pair      = {nib_q, nib};
	assign pair_no   = 9'((pos_q - 10'd2) >> 1);
	assign addr_bytes = (kind_q == RK_S1) ? 9'd2 : 9'd3;

	always_comb begin
		pos_n      = pos_q;
		kind_n     = kind_q;
		count_n    = count_q;
		addr_n     = addr_q;
		cur_n      = cur_q;
		nib_n      = nib_q;
		idx_n      = idx_q;
		lines_n    = lines_q;
		finished_n = finished_q;
		hit        = 1'b0;
		hit_res    = '0;
		s9         = 1'b0;
		ls_new     = lines_q;

		if (work && do_store) begin
			if (pos_q != 10'd1023) begin
				pos_n = pos_q + 10'd1;
			end
			if (pos_q == 10'd0) begin
				kind_n = (ev.ch == CH_S) ? RK_S_SEEN : RK_IGNORE;
				addr_n = '0;
				cur_n  = '0;
				idx_n  = '0;
			end else if (pos_q == 10'd1) begin
				if (kind_q == RK_S_SEEN) begin
					case (ev.ch)
						CH_ONE:  kind_n = RK_S1;
						CH_TWO:  kind_n = RK_S2;
						CH_NINE: kind_n = RK_S_SEEN;
						default: kind_n = RK_IGNORE;
					endcase
				end
			end else if (kind_q == RK_S1 || kind_q == RK_S2) begin
				if (!pos_q[0]) begin
					nib_n = nib;
				end else if (pair_no == 9'd0) begin
					count_n = pair;
				end else if (pair_no <= addr_bytes) begin
					addr_n = {addr_q[15:0], pair};
					cur_n  = {1'b0, addr_q[15:0], pair};
				end else begin
					// cur_q tracks the address of this data byte.
					if (({1'b0, idx_q} + addr_bytes + 9'd1) < {1'b0, count_q} &&
					    cur_q >= {1'b0, window_low} && cur_q <= {1'b0, window_high}) begin
						hit                = 1'b1;
						hit_res.kind       = KIND_WRITE;
						hit_res.offset     = 24'(cur_q - {1'b0, window_low});
						hit_res.byte_value = pair;
					end
					if (idx_q != 8'd255) begin
						idx_n = idx_q + 8'd1;
					end
					cur_n = cur_q + 25'd1;
				end
			end
		end

		if (work && (do_end || ev.op == EV_EOS)) begin
			if (do_end) begin
				s9 = (kind_n == RK_S_SEEN) && (pos_n >= 10'd2);
				if (!s9 && lines_q != 16'hffff) begin
					ls_new = lines_q + 16'd1;
				end
			end else if (pos_q != 10'd0) begin
				s9 = (kind_q == RK_S_SEEN) && (pos_q >= 10'd2);
				if (!s9 && lines_q != 16'hffff) begin
					ls_new = lines_q + 16'd1;
				end
			end
			lines_n = ls_new;
			if (s9) begin
				hit                     = 1'b1;
				hit_res                 = '0;
				hit_res.kind            = KIND_FINISH;
				hit_res.line_count      = lines_q;
				hit_res.terminator_seen = 1'b1;
				finished_n              = 1'b1;
			end else if (ev.op == EV_EOS) begin
				hit                = 1'b1;
				hit_res            = '0;
				hit_res.kind       = KIND_FINISH;
				if (ls_new == 16'd0 || ls_new == 16'hffff) begin
					hit_res.line_count = ls_new;
				end else begin
					hit_res.line_count = ls_new - 16'd1;
				end
				finished_n = 1'b1;
			end
			pos_n   = '0;
			kind_n  = RK_IGNORE;
			count_n = '0;
			addr_n  = '0;
			cur_n   = '0;
			nib_n   = '0;
			idx_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			kind_q      <= RK_IGNORE;
			count_q     <= '0;
			addr_q      <= '0;
			cur_q       <= '0;
			nib_q       <= '0;
			idx_q       <= '0;
			lines_q     <= '0;
			finished_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pos_q      <= pos_n;
			kind_q     <= kind_n;
			count_q    <= count_n;
			addr_q     <= addr_n;
			cur_q      <= cur_n;
			nib_q      <= nib_n;
			idx_q      <= idx_n;
			lines_q    <= lines_n;
			finished_q <= finished_n;
			if (hit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			res_q <= hit_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ rtl/srecord_window_loader.sv @@
// Top level of the S-record window loader: ports, window registers and wiring.
// The loader takes one character request per clock cycle. The front end sorts
// escapes, newlines and the line length limit and passes line events through a
// two-entry queue to the decoder, which handles one event per cycle and holds
// its result in an output register; an input request thus stalls only while
// that register is full and not taken and the queue has filled behind it.
// The request carrying a data byte's second hex digit is stored in a queue entry,
// and the byte is then held in the result register as it leaves the block.
module srecord_window_loader #(
	parameter int LINE_LIMIT = 520
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [23:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // ch
	input  logic         s_tuser,   // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [55:0]  m_tdata,   // offset, byte_value, line_count, terminator_seen
	output logic         m_tuser    // kind
);
	import slw_pkg::*;

	logic [23:0]  window_low_q, window_high_q;
	logic         accept, push, full, ev_valid, pop;
	ev_t          push_ev, ev;
	res_t         res;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= 24'h000000;
			window_high_q <= 24'hffffff;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LOW:  window_low_q  <= cfg_data;
				REG_WINDOW_HIGH: window_high_q <= cfg_data;
				default:         window_low_q  <= window_low_q;
			endcase
		end
	end

	slw_front #(
		.LINE_LIMIT (LINE_LIMIT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (s_tuser),
		.ch     (s_tdata),
		.push   (push),
		.ev     (push_ev)
	);

	slw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ev  (push_ev),
		.full     (full),
		.ev_valid (ev_valid),
		.ev       (ev),
		.pop      (pop)
	);

	slw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_valid    (ev_valid),
		.ev          (ev),
		.pop         (pop),
		.window_low  (window_low_q),
		.window_high (window_high_q),
		.res_valid   (m_tvalid),
		.res         (res),
		.res_ready   (m_tready)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {7'd0, res.terminator_seen, res.line_count, res.byte_value, res.offset};

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the S-record window loader with a behavioural predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slw_pkg::*;

	localparam int LINE_LIMIT = 520;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  ch;
		logic        typed;
		res_t        want;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_index = REG_WINDOW_LOW;
	logic [23:0]  cfg_data = 24'h0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h0;   // ch
	logic         s_tuser = CMD_CHAR;   // cmd
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [55:0]  m_tdata;   // offset, byte_value, line_count, terminator_seen
	logic         m_tuser;   // kind

	// Predictor copy of the loader state and window registers.
	logic [23:0]  win_lo = 24'h0;
	logic [23:0]  win_hi = 24'hFFFFFF;
	logic [9:0]   line_pos = '0;
	logic [9:0]   line_stp = '0;
	logic         esc_wait = 1'b0;
	rec_kind_t    rec = RK_IGNORE;
	logic [7:0]   rec_count = '0;
	logic [23:0]  rec_addr = '0;
	logic [3:0]   hi_nib = '0;
	logic [7:0]   data_idx = '0;
	logic [15:0]  lines_done = '0;
	logic         parse_done = 1'b0;

	res_t         loader_out_q[$];
	res_t         seen_res;
	res_t         want_res;
	int unsigned  fault_count = 0;
	int unsigned  items_sent = 0;
	int unsigned  burst_left = 0;
	bit           steady = 1'b0;
	int unsigned  stall_left = 0;
	int unsigned  take_pct = 100;

	// Opening record: S1, count 6, address 0010, escaped newline, invalid digits.
	stim_row_t demo_rows [21] = '{
		'{CMD_CHAR, CH_S,   1'b0, '0},
		'{CMD_CHAR, CH_ONE, 1'b0, '0},
		'{CMD_CHAR, 8'h30,  1'b0, '0},
		'{CMD_CHAR, 8'h36,  1'b0, '0},
		'{CMD_CHAR, 8'h30,  1'b0, '0},
		'{CMD_CHAR, 8'h30,  1'b0, '0},
		'{CMD_CHAR, 8'h31,  1'b0, '0},
		'{CMD_CHAR, 8'h30,  1'b0, '0},
		'{CMD_CHAR, 8'h41,  1'b0, '0},
		'{CMD_CHAR, 8'h62,  1'b1, '{KIND_WRITE, 24'h000010, 8'hAB, 16'h0, 1'b0}},
		'{CMD_CHAR, CH_BSL, 1'b0, '0},
		'{CMD_CHAR, CH_NL,  1'b0, '0},
		'{CMD_CHAR, 8'h67,  1'b0, '0},
		'{CMD_CHAR, 8'h46,  1'b1, '{KIND_WRITE, 24'h000011, 8'h0F, 16'h0, 1'b0}},
		'{CMD_CHAR, 8'hFF,  1'b0, '0},
		'{CMD_CHAR, 8'h35,  1'b1, '{KIND_WRITE, 24'h000012, 8'h05, 16'h0, 1'b0}},
		'{CMD_CHAR, 8'h39,  1'b0, '0},
		'{CMD_CHAR, 8'h39,  1'b0, '0},
		'{CMD_CHAR, CH_NL,  1'b0, '0},
		'{CMD_CHAR, 8'h00,  1'b0, '0},
		'{CMD_CHAR, CH_NL,  1'b0, '0}
	};

	srecord_window_loader #(
		.LINE_LIMIT(LINE_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
		if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
		return 4'h0;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		if ($urandom_range(0, 1) != 0) return 8'h37 + 8'(n);
		return 8'h57 + 8'(n);
	endfunction

	task automatic close_line(output bit hit, output res_t r);
		hit = 1'b0;
		r = '0;
		if (rec == RK_S_SEEN && line_pos >= 10'd2) begin
			r.kind = KIND_FINISH;
			r.line_count = lines_done;
			r.terminator_seen = 1'b1;
			parse_done = 1'b1;
			hit = 1'b1;
		end else if (lines_done != 16'hFFFF) begin
			lines_done++;
		end
		line_pos = '0;
		line_stp = '0;
		esc_wait = 1'b0;
		rec = RK_IGNORE;
		rec_count = '0;
		rec_addr = '0;
		hi_nib = '0;
		data_idx = '0;
	endtask

	task automatic take_char(input logic [7:0] c, output bit hit, output res_t r);
		logic [9:0]  p;
		logic [3:0]  nib;
		logic [7:0]  v;
		int unsigned pos;
		int unsigned q;
		int unsigned nbytes;
		int unsigned a;
		hit = 1'b0;
		r = '0;
		p = line_pos;
		if (line_pos < 10'd1023) line_pos++;
		if (p == 10'd0) begin
			rec = (c == CH_S) ? RK_S_SEEN : RK_IGNORE;
			rec_addr = '0;
			data_idx = '0;
		end else if (p == 10'd1) begin
			if (rec == RK_S_SEEN) begin
				case (c)
					CH_ONE:  rec = RK_S1;
					CH_TWO:  rec = RK_S2;
					CH_NINE: rec = RK_S_SEEN;
					default: rec = RK_IGNORE;
				endcase
			end
		end else if (rec == RK_S1 || rec == RK_S2) begin
			pos = p - 2;
			nib = digit_value(c);
			nbytes = (rec == RK_S1) ? 2 : 3;
			if (pos % 2 == 0) begin
				hi_nib = nib;
			end else begin
				v = {hi_nib, nib};
				q = pos / 2;
				if (q == 0) begin
					rec_count = v;
				end else if (q <= nbytes) begin
					rec_addr = {rec_addr[15:0], v};
				end else begin
					a = rec_addr + data_idx;
					// The address may run past 24 bits; such bytes never land in the window.
					if (data_idx + nbytes + 1 < rec_count && a >= win_lo && a <= win_hi) begin
						r.kind = KIND_WRITE;
						r.offset = 24'(a - win_lo);
						r.byte_value = v;
						hit = 1'b1;
					end
					if (data_idx != 8'd255) data_idx++;
				end
			end
		end
	endtask

	task automatic advance_loader(input logic cmd, input logic [7:0] c,
			output bit hit, output res_t r);
		bit   end_hit;
		res_t end_res;
		hit = 1'b0;
		r = '0;
		if (parse_done) return;
		if (cmd == CMD_EOS) begin
			if (line_pos != 10'd0) begin
				close_line(hit, r);
				if (hit) return;
			end
			r = '0;
			r.kind = KIND_FINISH;
			if (lines_done == 16'h0) r.line_count = 16'h0;
			else if (lines_done == 16'hFFFF) r.line_count = 16'hFFFF;
			else r.line_count = lines_done - 16'd1;
			parse_done = 1'b1;
			hit = 1'b1;
			return;
		end
		if (esc_wait) begin
			esc_wait = 1'b0;
			if (line_stp >= LINE_LIMIT - 1) close_line(hit, r);
			return;
		end
		if (c == CH_NL) begin
			close_line(hit, r);
			return;
		end
		line_stp++;
		if (c == CH_BSL) begin
			esc_wait = 1'b1;
			return;
		end
		take_char(c, hit, r);
		if (line_stp >= LINE_LIMIT - 1) begin
			close_line(end_hit, end_res);
			if (end_hit) begin
				hit = 1'b1;
				r = end_res;
			end
		end
	endtask

	// Sends one request in random-gapped bursts unless steady, then steps the predictor once taken.
	task automatic send_item(input logic cmd, input logic [7:0] c, output bit hit, output res_t r);
		int unsigned gap;
		if (!steady) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= c;
		do @(posedge clk); while (s_tready !== 1'b1);
		items_sent++;
		advance_loader(cmd, c, hit, r);
	endtask

	task automatic feed(input logic cmd, input logic [7:0] c);
		bit   hit;
		res_t r;
		send_item(cmd, c, hit, r);
		if (hit) loader_out_q.push_back(r);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (loader_out_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_window(input logic [23:0] lo, input logic [23:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_WINDOW_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_WINDOW_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_lo = lo;
		win_hi = hi;
		@(posedge clk);
	endtask

	function automatic logic [23:0] pick_addr();
		case ($urandom_range(0, 3))
			0:       return 24'($urandom);
			1:       return win_lo - 24'($urandom_range(0, 6));
			2:       return win_hi - 24'($urandom_range(0, 6));
			default: return win_lo + 24'($urandom_range(0, 20));
		endcase
	endfunction

	// mode 0: count matches the data, 1: count too short, 2: random count, 3: cut short.
	task automatic send_srec(input bit wide, input int mode);
		logic [7:0]  pairs[$];
		logic [23:0] addr;
		logic [3:0]  nib;
		int unsigned nbytes;
		int unsigned d;
		int unsigned cut_at;
		nbytes = wide ? 3 : 2;
		d = $urandom_range(0, 12);
		addr = pick_addr();
		case (mode)
			1:       pairs.push_back(8'($urandom_range(0, nbytes + 1)));
			2:       pairs.push_back(8'($urandom_range(0, 255)));
			default: pairs.push_back(8'(d + nbytes + 1));
		endcase
		if (wide) pairs.push_back(addr[23:16]);
		pairs.push_back(addr[15:8]);
		pairs.push_back(addr[7:0]);
		repeat (d + 1) pairs.push_back(8'($urandom));
		cut_at = $urandom_range(0, 2 * pairs.size() - 1);
		feed(CMD_CHAR, CH_S);
		feed(CMD_CHAR, wide ? CH_TWO : CH_ONE);
		for (int i = 0; i < 2 * pairs.size(); i++) begin
			if (mode == 3 && i == cut_at) break;
			nib = (i % 2 == 0) ? pairs[i / 2][7:4] : pairs[i / 2][3:0];
			if ($urandom_range(0, 29) == 0) begin
				feed(CMD_CHAR, CH_BSL);
				feed(CMD_CHAR, ($urandom_range(0, 3) == 0) ? CH_NL : 8'($urandom));
			end
			if ($urandom_range(0, 49) == 0) feed(CMD_CHAR, 8'($urandom));
			else feed(CMD_CHAR, hex_digit(nib));
		end
		feed(CMD_CHAR, CH_NL);
	endtask

	task automatic send_record();
		logic [7:0] c;
		case ($urandom_range(0, 19))
			11:     send_srec(1'($urandom_range(0, 1)), 1);
			12, 13: send_srec(1'($urandom_range(0, 1)), 2);
			14:     send_srec(1'($urandom_range(0, 1)), 3);
			15: begin
				// S0, S3 and stranger record types are skipped whole.
				case ($urandom_range(0, 2))
					0:       c = 8'h30;
					1:       c = 8'h33;
					default: do c = 8'($urandom); while (c == CH_ONE || c == CH_TWO ||
							c == CH_NINE || c == CH_NL || c == CH_BSL);
				endcase
				feed(CMD_CHAR, CH_S);
				feed(CMD_CHAR, c);
				repeat ($urandom_range(0, 20)) feed(CMD_CHAR, hex_digit(4'($urandom)));
				feed(CMD_CHAR, CH_NL);
			end
			16: begin
				do c = 8'($urandom); while (c == CH_S || c == CH_NL || c == CH_BSL);
				feed(CMD_CHAR, c);
				repeat ($urandom_range(0, 20)) begin
					do c = 8'($urandom); while (c == CH_NL);
					feed(CMD_CHAR, c);
				end
				feed(CMD_CHAR, CH_NL);
			end
			17: begin
				feed(CMD_CHAR, CH_S);
				feed(CMD_CHAR, CH_NL);
			end
			18:      feed(CMD_CHAR, CH_NL);
			default: send_srec(1'($urandom_range(0, 1)), 0);
		endcase
	endtask

	// A line that reaches the length limit, ending either on a stored character or an escape.
	task automatic send_long_line(input bit esc_end);
		feed(CMD_CHAR, CH_S);
		feed(CMD_CHAR, CH_ONE);
		feed(CMD_CHAR, hex_digit(4'hF));
		feed(CMD_CHAR, hex_digit(4'hF));
		repeat (4) feed(CMD_CHAR, hex_digit(4'h0));
		repeat (LINE_LIMIT - 10) feed(CMD_CHAR, hex_digit(4'($urandom)));
		if (esc_end) begin
			feed(CMD_CHAR, CH_BSL);
			feed(CMD_CHAR, 8'($urandom));
		end else begin
			feed(CMD_CHAR, hex_digit(4'($urandom)));
			feed(CMD_CHAR, hex_digit(4'($urandom)));
		end
		feed(CMD_CHAR, CH_NL);
	endtask

	task automatic report_fault(input string what);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%0t: %s: want kind=%0d offset=%h byte=%h lines=%0d term=%0d",
				$realtime, what, want_res.kind, want_res.offset, want_res.byte_value,
				want_res.line_count, want_res.terminator_seen);
			$display("%0t: %s: got  kind=%0d offset=%h byte=%h lines=%0d term=%0d",
				$realtime, what, seen_res.kind, seen_res.offset, seen_res.byte_value,
				seen_res.line_count, seen_res.terminator_seen);
		end
	endtask

	// The receiver switches between eager, patchy and fully stalled stretches.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(4, 48);
			case ($urandom_range(0, 4))
				0, 1:    take_pct = 100;
				2:       take_pct = 60;
				3:       take_pct = 25;
				default: take_pct = 0;
			endcase
		end
		stall_left--;
		m_tready <= ($urandom_range(1, 100) <= take_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			seen_res.kind = m_tuser;
			seen_res.offset = m_tdata[23:0];
			seen_res.byte_value = m_tdata[31:24];
			seen_res.line_count = m_tdata[47:32];
			seen_res.terminator_seen = m_tdata[48];
			if (loader_out_q.size() == 0) begin
				want_res = '0;
				report_fault("result with nothing outstanding");
			end else begin
				want_res = loader_out_q.pop_front();
				if (seen_res.kind !== want_res.kind || seen_res.offset !== want_res.offset ||
						seen_res.byte_value !== want_res.byte_value ||
						seen_res.line_count !== want_res.line_count ||
						seen_res.terminator_seen !== want_res.terminator_seen)
					report_fault("field mismatch");
			end
		end
	end

	initial begin
		#(20_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		bit          hit;
		res_t        r;
		int unsigned start;
		logic [23:0] lo;
		logic [23:0] hi;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (demo_rows[i]) begin
			send_item(demo_rows[i].cmd, demo_rows[i].ch, hit, r);
			if (demo_rows[i].typed) loader_out_q.push_back(demo_rows[i].want);
			else if (hit) loader_out_q.push_back(r);
		end

		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				settle();
				case (ph)
					1: write_window(24'h0, 24'h0);
					2: write_window(24'hFFFFFF, 24'hFFFFFF);
					3: begin
						lo = 24'($urandom_range(0, 16'hFFC0));
						write_window(lo, lo + 24'($urandom_range(0, 40)));
					end
					4: begin
						// Inverted window: nothing may be written.
						lo = 24'($urandom_range(64, 16'hFFFF));
						write_window(lo, lo - 24'($urandom_range(1, 30)));
					end
					5: begin
						lo = 24'($urandom);
						hi = lo + 24'($urandom_range(0, 24'hFFFFFF - lo));
						write_window(lo, hi);
					end
					default: write_window(24'h0, 24'hFFFFFF);
				endcase
			end
			steady = ($urandom_range(0, 3) == 0);
			if (ph == 0) send_long_line(1'($urandom_range(0, 1)));
			start = items_sent;
			while (items_sent - start < 90) send_record();
		end

		steady = 1'b0;

		case ($urandom_range(0, 3))
			0: begin
				feed(CMD_CHAR, CH_S);
				feed(CMD_CHAR, CH_NINE);
				repeat ($urandom_range(0, 8)) feed(CMD_CHAR, hex_digit(4'($urandom)));
				feed(CMD_CHAR, CH_NL);
			end
			1: begin
				feed(CMD_CHAR, CH_S);
				feed(CMD_CHAR, CH_NINE);
				feed(CMD_EOS, 8'($urandom));
			end
			2: begin
				feed(CMD_CHAR, CH_S);
				feed(CMD_CHAR, CH_ONE);
				feed(CMD_CHAR, hex_digit(4'($urandom)));
				feed(CMD_EOS, 8'($urandom));
			end
			default: feed(CMD_EOS, 8'($urandom));
		endcase

		// Once finished the loader must ignore everything, a second end of stream too.
		repeat (4) feed(CMD_CHAR, 8'($urandom));
		feed(CMD_EOS, 8'($urandom));

		s_tvalid <= 1'b0;
		while (loader_out_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
